// ===== hw/rtl/furthest_vertex_from_plane_core_defines.svh =====
// Assertion helpers for the furthest vertex core
`ifndef FURTHEST_VERTEX_FROM_PLANE_CORE_DEFINES_SVH
`define FURTHEST_VERTEX_FROM_PLANE_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define FVP_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Same, but also checked during reset
`define FVP_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

// ===== hw/rtl/fvp_pkg.sv =====
package fvp_pkg;

  localparam int AddrWidth  = 10;
  localparam int Depth      = 1024;
  localparam int CoordWidth = 16;
  localparam int CountWidth = 11;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * DiffWidth;
  localparam int NormWidth  = ProdWidth + 1;
  localparam int TermWidth  = DiffWidth + NormWidth;
  localparam int DotWidth   = TermWidth + 2;
  localparam int DistWidth  = 54;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                           op;
    logic [AddrWidth-1:0]           load_index;
    logic signed [CoordWidth-1:0]   coord_x;
    logic signed [CoordWidth-1:0]   coord_y;
    logic signed [CoordWidth-1:0]   coord_z;
    logic [AddrWidth-1:0]           plane_a;
    logic [AddrWidth-1:0]           plane_b;
    logic [AddrWidth-1:0]           plane_c;
  } cmd_t;

  typedef struct packed {
    logic [AddrWidth-1:0] far_index;
    logic                 inverted;
    logic [DistWidth-1:0] far_distance;
  } result_t;

  // queued job from front to back
  typedef struct packed {
    logic                 op;
    logic [AddrWidth-1:0] load_index;
    logic [3*CoordWidth-1:0] vertex;
    logic [AddrWidth-1:0] plane_a;
    logic [AddrWidth-1:0] plane_b;
    logic [AddrWidth-1:0] plane_c;
    logic [CountWidth-1:0] limit;
  } job_t;

  // queue handshake status
  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } qctl_t;

endpackage

// ===== hw/rtl/fvp_front.sv =====
module fvp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  fvp_pkg::cmd_t                    cmd,
  input  logic                             cfg_we,
  input  logic [fvp_pkg::CountWidth-1:0]   cfg_data,
  input  logic                             pop,
  output logic                             busy,
  output logic                             job_valid,
  output fvp_pkg::job_t                    job
);

  fvp_pkg::job_t                   q [fvp_pkg::QueueDepth];
  logic [fvp_pkg::QueuePtrW-1:0]   wr_ptr;
  logic [fvp_pkg::QueuePtrW-1:0]   rd_ptr;
  logic [fvp_pkg::QueuePtrW:0]     fill;
  logic [fvp_pkg::CountWidth-1:0]  vertex_count;
  logic [fvp_pkg::CountWidth-1:0]  limit;
  fvp_pkg::qctl_t                  ctl;

  // clamp the count to 1 .. Depth
  always_comb begin
    limit = vertex_count;
    if (vertex_count == '0) begin
      limit = fvp_pkg::CountWidth'(1);
    end else if (vertex_count > fvp_pkg::CountWidth'(fvp_pkg::Depth)) begin
      limit = fvp_pkg::CountWidth'(fvp_pkg::Depth);
    end
  end

  assign ctl.full  = (fill == (fvp_pkg::QueuePtrW+1)'(fvp_pkg::QueueDepth));
  assign ctl.empty = (fill == '0);
  assign ctl.push  = start && !busy;
  assign ctl.pop   = pop && !ctl.empty;
  assign busy      = ctl.full;
  assign job_valid = !ctl.empty;
  assign job       = q[rd_ptr];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= fvp_pkg::CountWidth'(1);
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q[wr_ptr].op         <= cmd.op;
      q[wr_ptr].load_index <= cmd.load_index;
      q[wr_ptr].vertex     <= {cmd.coord_x, cmd.coord_y, cmd.coord_z};
      q[wr_ptr].plane_a    <= cmd.plane_a;
      q[wr_ptr].plane_b    <= cmd.plane_b;
      q[wr_ptr].plane_c    <= cmd.plane_c;
      q[wr_ptr].limit      <= limit;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (ctl.push) wr_ptr <= wr_ptr + 1'b1;
      if (ctl.pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({ctl.push, ctl.pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/fvp_back.sv =====
module fvp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  fvp_pkg::job_t   job,
  output logic            pop,
  output logic            idle,
  output logic            done,
  output fvp_pkg::result_t result
);

  localparam int CW = fvp_pkg::CoordWidth;
  localparam int DW = fvp_pkg::DiffWidth;
  localparam int PW = fvp_pkg::ProdWidth;
  localparam int NW = fvp_pkg::NormWidth;
  localparam int TW = fvp_pkg::TermWidth;
  localparam int XW = fvp_pkg::DotWidth;
  localparam int AW = fvp_pkg::AddrWidth;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDA   = 9'b000000010,
    S_RDB   = 9'b000000100,
    S_RDC   = 9'b000001000,
    S_DIFF  = 9'b000010000,
    S_PROD  = 9'b000100000,
    S_NORM  = 9'b001000000,
    S_WALK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [3*CW-1:0] mem [fvp_pkg::Depth];
  logic [3*CW-1:0] rdata;
  logic [AW-1:0]   raddr;
  logic            rd_en;

  logic signed [CW-1:0] ax, ay, az, bx, by, bz;
  logic signed [DW-1:0] ux, uy, uz, wx, wy, wz;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [NW-1:0] nx, ny, nz;
  logic signed [TW-1:0] tx, ty, tz;
  logic signed [XW-1:0] dot;
  logic [XW-1:0]        mag;
  logic [fvp_pkg::CountWidth-1:0] issue, limit;
  logic [AW-1:0]        plane_b, plane_c;
  logic [AW-1:0]        t_idx;
  logic                 t_valid, t_first;
  logic                 s_valid, s_first;
  logic [AW-1:0]        s_idx;
  logic [XW-1:0]        best_abs;
  logic                 best_neg;
  logic [AW-1:0]        best_idx;
  logic signed [CW-1:0] vx, vy, vz;

  assign idle = (state == S_IDLE);
  assign pop  = (state == S_IDLE) && job_valid;

  // store: one write, one registered read; the read holds in S_RDC so c stays
  always_comb begin
    rd_en = (state != S_RDC);
    case (state)
      S_IDLE:  raddr = job.plane_a;
      S_RDA:   raddr = plane_b;
      S_RDB:   raddr = plane_c;
      default: raddr = issue[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && job.op == fvp_pkg::OP_LOAD) begin
      mem[job.load_index] <= job.vertex;
    end
    if (rd_en) rdata <= mem[raddr];
  end

  assign vx = rdata[3*CW-1:2*CW];
  assign vy = rdata[2*CW-1:CW];
  assign vz = rdata[CW-1:0];

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (pop && job.op == fvp_pkg::OP_QUERY) state_next = S_RDA;
      S_RDA:   state_next = S_RDB;
      S_RDB:   state_next = S_RDC;
      S_RDC:   state_next = S_DIFF;
      S_DIFF:  state_next = S_PROD;
      S_PROD:  state_next = S_NORM;
      S_NORM:  state_next = S_WALK;
      S_WALK:  if (issue == limit && !t_valid && !s_valid) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // plane set-up: latch a, b, then differences, products, normal
  always_ff @(posedge clk) begin
    if (pop) begin
      limit   <= job.limit;
      plane_b <= job.plane_b;
      plane_c <= job.plane_c;
    end
    case (state)
      S_RDA: begin
        ax <= vx; ay <= vy; az <= vz;
      end
      S_RDB: begin
        bx <= vx; by <= vy; bz <= vz;
      end
      S_DIFF: begin
        ux <= DW'(bx) - DW'(ax);
        uy <= DW'(by) - DW'(ay);
        uz <= DW'(bz) - DW'(az);
        wx <= DW'(vx) - DW'(ax);
        wy <= DW'(vy) - DW'(ay);
        wz <= DW'(vz) - DW'(az);
      end
      S_PROD: begin
        p0 <= uy * wz; p1 <= uz * wy;
        p2 <= uz * wx; p3 <= ux * wz;
        p4 <= ux * wy; p5 <= uy * wx;
      end
      S_NORM: begin
        nx <= NW'(p0) - NW'(p1);
        ny <= NW'(p2) - NW'(p3);
        nz <= NW'(p4) - NW'(p5);
      end
      default: ;
    endcase
  end

  // rdata holds a in S_RDA, b in S_RDB and c from S_RDC through S_DIFF

  // walk: issue read, products, sum and compare
  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      s_valid <= 1'b0;
      issue   <= '0;
    end else begin
      if (state == S_NORM) issue <= '0;
      else if (state == S_WALK && issue != limit) issue <= issue + 1'b1;
      t_valid <= (state == S_WALK) && (issue != limit);
      s_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    t_idx   <= issue[AW-1:0];
    t_first <= (issue == '0);
    tx <= (DW'(vx) - DW'(ax)) * nx;
    ty <= (DW'(vy) - DW'(ay)) * ny;
    tz <= (DW'(vz) - DW'(az)) * nz;
    s_idx   <= t_idx;
    s_first <= t_first;
  end

  assign dot = XW'(tx) + XW'(ty) + XW'(tz);
  assign mag = dot[XW-1] ? XW'(-dot) : XW'(dot);

  always_ff @(posedge clk) begin
    if (s_valid && (s_first || mag > best_abs)) begin
      best_abs <= mag;
      best_neg <= dot[XW-1];
      best_idx <= s_idx;
    end
  end

  assign done = (state == S_DONE);
  assign result.far_index    = best_idx;
  assign result.inverted     = best_neg;
  assign result.far_distance = best_abs[fvp_pkg::DistWidth-1:0];

endmodule

// ===== hw/rtl/furthest_vertex_from_plane_core.sv =====
// Furthest vertex from plane.
// Input channel: start/busy with one cmd transaction per accepted edge
// (start high, busy low). op LOAD writes one vertex to the store and gives
// no result; op QUERY walks vertices 0 .. count-1 against the plane a, b, c.
// Config: cfg_we/cfg_data write vertex_count at any edge; no read-back.
// Output: done is high for exactly one cycle with the result; the receiver
// cannot hold it off, so no stall exists on this side.
// Commands pass through a two-entry queue to the execution side.
// A load is written to the vertex store when the execution side pops it; a
// query's walk is paced by the single read port of the vertex store,
// which delivers one vertex a cycle during the walk.
// busy rises only while the queue is full.
// Reset clears the queue, the sequencer and sets vertex_count to 1; the
// vertex store is not cleared and must be loaded before it is queried.
// The count that a query walks is vertex_count clamped to 1 .. Depth.
`include "furthest_vertex_from_plane_core_defines.svh"

module furthest_vertex_from_plane_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  fvp_pkg::cmd_t                    cmd,
  input  logic                             cfg_we,
  input  logic [fvp_pkg::CountWidth-1:0]   cfg_data,
  output logic                             done,
  output fvp_pkg::result_t                 result
);

  logic          pop, job_valid, idle;
  fvp_pkg::job_t job;

  fvp_front u_front (
    .clk, .rst, .start, .cmd, .cfg_we, .cfg_data, .pop,
    .busy, .job_valid, .job
  );

  fvp_back u_back (
    .clk, .rst, .job_valid, .job, .pop, .idle, .done, .result
  );

  `FVP_ASSERT(a_done_one_cycle, clk, rst, done |=> !done, "done held")
  `FVP_ASSERT(a_pop_when_idle, clk, rst, pop |-> idle && job_valid, "pop while working")
  `FVP_ASSERT(a_done_not_idle, clk, rst, done |-> !idle, "done while idle")

endmodule

// ===== sim/furthest_vertex_from_plane_checker.sv =====
module furthest_vertex_from_plane_checker
  import fvp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  cmd_t                  cmd,
  input  logic                  cfg_we,
  input  logic [CountWidth-1:0] cfg_data,
  input  logic                  done,
  input  result_t               result,
  output int                    fails,
  output int                    pending
);

  // own copy of the vertex store and the search count
  longint          store_x [Depth];
  longint          store_y [Depth];
  longint          store_z [Depth];
  int unsigned     search_count;
  result_t         far_results [$];

  initial begin
    fails = 0;
    pending = 0;
    search_count = 1;
    for (int i = 0; i < Depth; i++) begin
      store_x[i] = 0;
      store_y[i] = 0;
      store_z[i] = 0;
    end
  end

  // furthest vertex from the plane through a, b, c over the searched prefix
  function automatic result_t far_vertex(cmd_t c);
    longint  ax, ay, az, ux, uy, uz, wx, wy, wz, nx, ny, nz, d, mag, best_abs;
    int      lim, best_idx;
    logic    best_neg;
    result_t r;
    ax = store_x[c.plane_a]; ay = store_y[c.plane_a]; az = store_z[c.plane_a];
    ux = store_x[c.plane_b] - ax; uy = store_y[c.plane_b] - ay; uz = store_z[c.plane_b] - az;
    wx = store_x[c.plane_c] - ax; wy = store_y[c.plane_c] - ay; wz = store_z[c.plane_c] - az;
    nx = uy * wz - uz * wy;
    ny = uz * wx - ux * wz;
    nz = ux * wy - uy * wx;
    lim = search_count;
    if (lim > Depth) lim = Depth;
    if (lim < 1) lim = 1;
    best_idx = 0;
    best_abs = 0;
    best_neg = 1'b0;
    for (int i = 0; i < lim; i++) begin
      d = (store_x[i] - ax) * nx + (store_y[i] - ay) * ny + (store_z[i] - az) * nz;
      mag = (d < 0) ? -d : d;
      if (i == 0 || mag > best_abs) begin
        best_idx = i;
        best_abs = mag;
        best_neg = d < 0;
      end
    end
    r.far_index    = best_idx[AddrWidth-1:0];
    r.inverted     = best_neg;
    r.far_distance = best_abs[DistWidth-1:0];
    return r;
  endfunction

  // watch both channels; a result is compared before the same edge's transaction is taken
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      search_count = 1;
    end else begin
      if (done) begin
        if (far_results.size() == 0) begin
          $error("result with none expected: index %0d", result.far_index);
          fails++;
        end else begin
          want = far_results.pop_front();
          if (result.far_index !== want.far_index) begin
            $error("far_index expected %0d got %0d", want.far_index, result.far_index);
            fails++;
          end
          if (result.inverted !== want.inverted) begin
            $error("inverted expected %0d got %0d", want.inverted, result.inverted);
            fails++;
          end
          if (result.far_distance !== want.far_distance) begin
            $error("far_distance expected %0d got %0d", want.far_distance,
                   result.far_distance);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        if (cmd.op == OP_LOAD) begin
          store_x[cmd.load_index] = cmd.coord_x;
          store_y[cmd.load_index] = cmd.coord_y;
          store_z[cmd.load_index] = cmd.coord_z;
        end else begin
          far_results.push_back(far_vertex(cmd));
        end
      end
      if (cfg_we) search_count = cfg_data;
    end
    pending = far_results.size();
  end

endmodule

// ===== sim/furthest_vertex_from_plane_core_tb.sv =====
module furthest_vertex_from_plane_core_tb;
  import fvp_pkg::*;

  localparam int IdleLimit = 6000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  cmd_t                  cmd = '0;
  logic                  cfg_we = 1'b0;
  logic [CountWidth-1:0] cfg_data = '0;
  logic                  done;
  result_t               result;
  int                    fails;
  int                    pending;

  // which store entries hold a vertex; queries only name these
  bit                    loaded [Depth];
  int                    loaded_list [$];
  int                    burst_left = 0;
  int                    idle_cycles = 0;

  always #10 clk = ~clk;

  furthest_vertex_from_plane_core u_dut (
    .clk, .rst, .start, .busy, .cmd, .cfg_we, .cfg_data, .done, .result
  );

  furthest_vertex_from_plane_checker u_check (
    .clk, .rst, .start, .busy, .cmd, .cfg_we, .cfg_data, .done, .result,
    .fails, .pending
  );

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("furthest_vertex_from_plane_core_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [CoordWidth-1:0] rand_coord();
    case ($urandom_range(0, 11))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return CoordWidth'($urandom);
    endcase
  endfunction

  // send one transaction, with bursts and random gaps in front
  task automatic send(input cmd_t c);
    logic was_busy;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    cmd   <= c;
    forever begin
      #1 was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
      @(negedge clk);
    end
    if (c.op == OP_LOAD && !loaded[c.load_index]) begin
      loaded[c.load_index] = 1'b1;
      loaded_list.push_back(c.load_index);
    end
  endtask

  task automatic load_vertex(input int idx, input logic [CoordWidth-1:0] x,
                             input logic [CoordWidth-1:0] y, input logic [CoordWidth-1:0] z);
    cmd_t c;
    c = cmd_t'({$urandom, $urandom, $urandom});
    c.op = OP_LOAD;
    c.load_index = AddrWidth'(idx);
    c.coord_x = x;
    c.coord_y = y;
    c.coord_z = z;
    send(c);
  endtask

  task automatic query(input int a, input int b, input int c3);
    cmd_t c;
    c = cmd_t'({$urandom, $urandom, $urandom});
    c.op = OP_QUERY;
    c.plane_a = AddrWidth'(a);
    c.plane_b = AddrWidth'(b);
    c.plane_c = AddrWidth'(c3);
    send(c);
  endtask

  function automatic int pick_loaded(input int below);
    int idx;
    do idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    while (idx >= below);
    return idx;
  endfunction

  // random mix; queries name loaded entries below span, loads stay below span
  task automatic random_items(input int n, input int span);
    int a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        load_vertex($urandom_range(0, span - 1), rand_coord(), rand_coord(), rand_coord());
      end else begin
        a = pick_loaded(span);
        if ($urandom_range(0, 9) == 0) query(a, a, pick_loaded(span));
        else query(a, pick_loaded(span), pick_loaded(span));
      end
    end
  endtask

  // drain the block, then let trailing loads finish before a register write
  task automatic set_count(input int value, input int settle);
    @(negedge clk);
    start <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= CountWidth'(value);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extreme coordinates, degenerate and collinear planes, tiny counts
    load_vertex(0, 16'h0000, 16'h0000, 16'h0000);
    load_vertex(1, 16'h7fff, 16'h7fff, 16'h7fff);
    load_vertex(2, 16'h8000, 16'h8000, 16'h8000);
    load_vertex(3, 16'h7fff, 16'h8000, 16'h0000);
    load_vertex(4, 16'h8000, 16'h0000, 16'h7fff);
    load_vertex(5, 16'h0100, 16'h0000, 16'h0000);
    load_vertex(6, 16'h0000, 16'h0100, 16'h0000);
    load_vertex(7, 16'h0000, 16'h0000, 16'h0100);
    query(0, 5, 6);
    query(1, 1, 1);
    query(0, 1, 2);
    set_count(0, 20);
    query(5, 6, 7);
    query(2, 3, 4);
    set_count(8, 20);
    query(0, 5, 6);
    query(0, 6, 5);
    query(5, 6, 7);
    query(3, 4, 1);
    query(2, 3, 4);
    query(1, 1, 2);
    query(0, 1, 2);
    query(4, 3, 2);

    // small store, many short queries
    for (int i = 8; i < 40; i++)
      load_vertex(i, rand_coord(), rand_coord(), rand_coord());
    set_count(40, 60);
    random_items(100, 40);

    // fill the whole store
    for (int i = 0; i < Depth; i++)
      load_vertex(i, rand_coord(), rand_coord(), rand_coord());

    // count beyond the store, full store, then a mid-size mix
    set_count(2047, 1100);
    random_items(3, Depth);
    set_count(1024, 1100);
    query($urandom_range(0, Depth - 1), $urandom_range(0, Depth - 1),
          $urandom_range(0, Depth - 1));
    query(1023, 1023, 0);
    set_count(100, 1100);
    random_items(60, Depth);
    set_count(1, 200);
    random_items(10, Depth);

    // drain and let the block settle
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (1100) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("furthest_vertex_from_plane_core_tb OK");
    end else begin
      $display("furthest_vertex_from_plane_core_tb NOT OK");
    end
    $finish;
  end

endmodule
